>>> design/ois_pkg.sv
// ============================================================================
// ois_pkg: shared definitions for the ordered ID set
// Operation codes, field widths and the result record passed to the top level.
// ============================================================================
package ois_pkg;

    localparam int OP_W    = 2;
    localparam int ID_W    = 22;
    localparam int COUNT_W = 5;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    typedef struct packed {
        logic               found;
        logic               overflow;
        logic [COUNT_W-1:0] count;
    } res_t;

endpackage

>>> design/ois_ram.sv
// ============================================================================
// ois_ram: slot memory
// One write port and one read port with registered read data.
// ============================================================================
module ois_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [ois_pkg::ID_W-1:0]   wdata,
    input  logic [AW-1:0]              raddr,
    output logic [ois_pkg::ID_W-1:0]   rdata
);

    logic [ois_pkg::ID_W-1:0] mem [DEPTH];
    logic [ois_pkg::ID_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/ois_engine.sv
// ============================================================================
// ois_engine: search and shift sequencer
// Walks the slot memory one entry per cycle with a single comparator, and
// closes the gap after a removal by copying later entries down one slot.
// ============================================================================
module ois_engine #(
    parameter int CAPACITY = 16,
    parameter int AW       = 4,
    parameter int CW       = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ois_pkg::OP_W-1:0]    op,
    input  logic [ois_pkg::ID_W-1:0]    proc_id,
    output logic                        busy,
    output logic                        res_valid,
    input  logic                        res_ready,
    output ois_pkg::res_t               res,
    output logic                        mem_we,
    output logic [AW-1:0]               mem_waddr,
    output logic [ois_pkg::ID_W-1:0]    mem_wdata,
    output logic [AW-1:0]               mem_raddr,
    input  logic [ois_pkg::ID_W-1:0]    mem_rdata
);

    localparam int COUNT_W = ois_pkg::COUNT_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_SHIFT  = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            idx_reg, idx_next;
    logic [CW-1:0]            fill_reg, fill_next;
    logic [CW-1:0]            rd_idx;
    logic                     found_reg, found_next;
    logic                     ovf_reg, ovf_next;
    logic [ois_pkg::OP_W-1:0] op_reg, op_next;
    logic [ois_pkg::ID_W-1:0] id_reg, id_next;
    logic                     hit;

    assign hit = (mem_rdata == id_reg);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        fill_next  = fill_reg;
        found_next = found_reg;
        ovf_next   = ovf_reg;
        op_next    = op_reg;
        id_next    = id_reg;
        rd_idx     = idx_reg;
        mem_we     = 1'b0;
        mem_waddr  = fill_reg[AW-1:0];
        mem_wdata  = id_reg;
        res_valid  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    id_next    = proc_id;
                    op_next    = op;
                    found_next = 1'b0;
                    ovf_next   = 1'b0;
                    idx_next   = '0;
                    rd_idx     = '0;
                    unique case (op) inside
                        ois_pkg::OP_ADD:
                        begin
                            if (fill_reg == CW'(CAPACITY))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = proc_id;
                                fill_next = fill_reg + CW'(1);
                            end
                            state_next = ST_DONE;
                        end
                        ois_pkg::OP_REMOVE, ois_pkg::OP_QUERY:
                        begin
                            state_next = (fill_reg == '0) ? ST_DONE : ST_SEARCH;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    state_next = ST_DONE;
                    if (op_reg == ois_pkg::OP_REMOVE)
                    begin
                        fill_next = fill_reg - CW'(1);
                        // close the gap only if later entries exist
                        if (idx_reg < fill_reg - CW'(1))
                        begin
                            rd_idx     = idx_reg + CW'(1);
                            state_next = ST_SHIFT;
                        end
                    end
                end
                else if (idx_reg + CW'(1) < fill_reg)
                begin
                    idx_next = idx_reg + CW'(1);
                    rd_idx   = idx_reg + CW'(1);
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT:
            begin
                // read data holds the entry one above idx
                mem_we    = 1'b1;
                mem_waddr = idx_reg[AW-1:0];
                mem_wdata = mem_rdata;
                if (idx_reg + CW'(1) < fill_reg)
                begin
                    idx_next = idx_reg + CW'(1);
                    rd_idx   = idx_reg + CW'(2);
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign mem_raddr    = rd_idx[AW-1:0];
    assign busy         = (state_reg != ST_IDLE);
    assign res.found    = found_reg;
    assign res.overflow = ovf_reg;
    assign res.count    = COUNT_W'(fill_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        found_reg <= found_next;
        ovf_reg   <= ovf_next;
        op_reg    <= op_next;
        id_reg    <= id_next;
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(CAPACITY))
        else $error("fill count above capacity");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH || state_reg == ST_SHIFT) |-> idx_reg < fill_reg)
        else $error("walk index beyond filled slots");

    a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_SHIFT || (state_reg == ST_IDLE && start)))
        else $error("slot write outside add or shift");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> $stable(fill_reg))
        else $error("fill changed while result pending");
`endif

endmodule

>>> design/ordered_id_set_add_remove_query_top.sv
// ============================================================================
// ordered_id_set_add_remove_query_top: ordered list of process identifiers
// Add, remove with order-keeping shift, and membership query over a bounded
// list, with a registered result stage toward the consumer.
// ============================================================================
// Sequence: add or an unknown code goes from the request straight to the done
//   state; query and remove first compare entries in order, and remove then
//   shifts later entries down; every result then passes the output register.
// Requests: one is taken only after the last result has moved into the output
//   register; the single comparator walks the slot memory's one read port one
//   entry per cycle, and a stalled response holds the sequencer and requests.
// Reset: the fill count clears to zero and the sequencer idles; slot contents
//   are not cleared, since only slots below the fill count are ever compared or copied.
module ordered_id_set_add_remove_query_top #(
    parameter int CAPACITY = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // request channel
    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic [ois_pkg::OP_W-1:0]           op,
    input  logic [ois_pkg::ID_W-1:0]           proc_id,
    // response channel
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic                               found,
    output logic                               overflow,
    output logic [ois_pkg::COUNT_W-1:0]        count
);

    // Slot address width; a one-entry list still gets a one-bit address.
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    // Counter width, wide enough to hold CAPACITY itself.
    localparam int CW = $clog2(CAPACITY + 1);

    logic                     busy;
    logic                     start;
    logic                     res_valid;
    logic                     res_ready;
    ois_pkg::res_t            res;
    ois_pkg::res_t            rsp_reg;
    logic                     rsp_valid_reg;
    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic [ois_pkg::ID_W-1:0] mem_wdata;
    logic [AW-1:0]            mem_raddr;
    logic [ois_pkg::ID_W-1:0] mem_rdata;

    // Hold off new requests while the engine searches, shifts or holds a result.
    assign req_stall = busy;
    assign start     = req_valid && !busy;

    ois_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ois_engine #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .op        (op),
        .proc_id   (proc_id),
        .busy      (busy),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // Output register: take a new result when empty or when the held one
    // leaves this cycle; the engine holds its result while the consumer stalls.
    assign res_ready = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Payload: load only on a transfer into the stage, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign found     = rsp_reg.found;
    assign overflow  = rsp_reg.overflow;
    assign count     = rsp_reg.count;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top: self-checking bench for the ordered process ID list
// Drives add, remove and query requests through the valid/stall channels.
// Mirrors the list contents in a scoreboard to predict found, overflow and
// count, and checks each response in order. Idle and stall load varies by
// phase. One phase holds the response side off long enough to back up the
// request side.
// ============================================================================
module tb_top;

    localparam int LIST_DEPTH = 16;
    localparam int POOL_SIZE  = 8;
    localparam int LONG_HOLD  = 300;
    localparam int DRAIN_CAP  = 50000;
    // Unassigned opcode; the block must ignore it.
    localparam logic [ois_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the ID list, predicts each response
    // when a request is accepted, and checks responses in arrival order.
    // ------------------------------------------------------------------------
    class id_list_checker;
        logic [ois_pkg::ID_W-1:0] held_ids[$];
        ois_pkg::res_t            pending_results[$];
        int                       depth;
        int unsigned              mismatches;
        int unsigned              requests;
        int unsigned              responses;
        int unsigned              refused_adds;
        int unsigned              removals;
        int unsigned              query_hits;
        int                       peak_fill;

        function new(int list_depth);
            depth = list_depth;
        endfunction

        // Apply one request to the list copy and queue the response it owes.
        function void take_request(logic [ois_pkg::OP_W-1:0] code,
                                   logic [ois_pkg::ID_W-1:0] id);
            ois_pkg::res_t r;
            int            pos;
            r   = '0;
            pos = -1;
            // First match from the front, as the block's search does.
            for (int i = 0; i < held_ids.size(); i++)
            begin
                if (pos < 0 && held_ids[i] == id)
                    pos = i;
            end
            case (code)
                ois_pkg::OP_ADD:
                begin
                    if (held_ids.size() >= depth)
                    begin
                        r.overflow = 1'b1;
                        refused_adds++;
                    end
                    else
                        held_ids.push_back(id);
                end
                ois_pkg::OP_REMOVE:
                begin
                    if (pos >= 0)
                    begin
                        r.found = 1'b1;
                        held_ids.delete(pos);
                        removals++;
                    end
                end
                ois_pkg::OP_QUERY:
                begin
                    r.found = (pos >= 0);
                    if (pos >= 0)
                        query_hits++;
                end
                default: ;
            endcase
            r.count = ois_pkg::COUNT_W'(held_ids.size());
            if (held_ids.size() > peak_fill)
                peak_fill = held_ids.size();
            pending_results.push_back(r);
            requests++;
        endfunction

        function void check_response(logic fnd, logic ovf,
                                     logic [ois_pkg::COUNT_W-1:0] cnt);
            ois_pkg::res_t want;
            responses++;
            if (pending_results.size() == 0)
            begin
                $error("response with no request outstanding: found=%0d overflow=%0d count=%0d",
                       fnd, ovf, cnt);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (fnd !== want.found)
            begin
                $error("found: expected %0d, actual %0d", want.found, fnd);
                mismatches++;
            end
            if (ovf !== want.overflow)
            begin
                $error("overflow: expected %0d, actual %0d", want.overflow, ovf);
                mismatches++;
            end
            if (cnt !== want.count)
            begin
                $error("count: expected %0d, actual %0d", want.count, cnt);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero.
    // ------------------------------------------------------------------------
    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        req_valid = 1'b0;
    logic [ois_pkg::OP_W-1:0]    op        = ois_pkg::OP_ADD;
    logic [ois_pkg::ID_W-1:0]    proc_id   = '0;
    logic                        rsp_stall = 1'b0;
    logic                        req_stall;
    logic                        rsp_valid;
    logic                        found;
    logic                        overflow;
    logic [ois_pkg::COUNT_W-1:0] count;

    // Load knobs, set per phase by the main sequence.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    // Long hold-off handshake: main bumps hold_orders, the stall process
    // serves each order once and counts the hold down itself.
    int hold_orders = 0;
    int hold_served = 0;
    int hold_left   = 0;

    logic [ois_pkg::ID_W-1:0] id_pool[POOL_SIZE];
    id_list_checker           list_chk = new(LIST_DEPTH);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ordered_id_set_add_remove_query_top #(
        .CAPACITY (LIST_DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .op        (op),
        .proc_id   (proc_id),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .found     (found),
        .overflow  (overflow),
        .count     (count)
    );

    // ------------------------------------------------------------------------
    // Monitors: sample both handshakes on the pre-edge values. All bench
    // drives are nonblocking, so ordering within the step does not matter.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
            list_chk.take_request(op, proc_id);
        if (rst_n && rsp_valid && !rsp_stall)
            list_chk.check_response(found, overflow, count);
    end

    // Response-side stall: random per phase, or a long counted hold when ordered.
    always @(posedge clk)
    begin
        if (hold_left == 0 && hold_orders != hold_served)
        begin
            hold_served = hold_served + 1;
            hold_left   = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    // Hard limit on run time, far beyond the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Request driver. Insert idle cycles at random, then hold the request
    // until it is taken. Valid stays high on return so back-to-back requests
    // need no second assignment in the same step.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [ois_pkg::OP_W-1:0] code,
                                input logic [ois_pkg::ID_W-1:0] id);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        op        <= code;
        proc_id   <= id;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // Drop valid and wait until every predicted response has been seen,
    // then allow the block's worst-case latency to pass.
    task automatic wait_for_results();
        int spins;
        spins     = 0;
        req_valid <= 1'b0;
        @(posedge clk);
        while (list_chk.pending() != 0 && spins < DRAIN_CAP)
        begin
            spins++;
            @(posedge clk);
        end
        repeat (LIST_DEPTH + 4) @(posedge clk);
    endtask

    // Draw a fresh set of IDs so adds, removes and queries collide often.
    task automatic refresh_pool();
        for (int i = 0; i < POOL_SIZE; i++)
            id_pool[i] = ois_pkg::ID_W'($urandom);
    endtask

    // Random traffic. Re-weight adds every 40 requests so the fill level
    // wanders between empty and full; most IDs come from the small pool.
    task automatic run_random(input int n);
        int                       add_w;
        int                       roll;
        logic [ois_pkg::OP_W-1:0] code;
        logic [ois_pkg::ID_W-1:0] id;
        add_w = 50;
        for (int k = 0; k < n; k++)
        begin
            if (k % 40 == 0)
                add_w = $urandom_range(20, 75);
            roll = $urandom_range(99);
            if (roll < 3)
                code = OP_UNUSED;
            else if (roll < 3 + add_w)
                code = ois_pkg::OP_ADD;
            else if (roll < 3 + add_w + (97 - add_w) * 2 / 3)
                code = ois_pkg::OP_REMOVE;
            else
                code = ois_pkg::OP_QUERY;
            if ($urandom_range(99) < 80)
                id = id_pool[$urandom_range(POOL_SIZE - 1)];
            else
                id = ois_pkg::ID_W'($urandom);
            send_request(code, id);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-list cases, the unused opcode, extreme IDs,
        // duplicates, first-match removal, filling up and refused add.
        send_request(ois_pkg::OP_QUERY, '0);
        send_request(ois_pkg::OP_REMOVE, 22'd5);
        send_request(OP_UNUSED, '1);
        send_request(ois_pkg::OP_ADD, '0);
        send_request(ois_pkg::OP_ADD, '1);
        send_request(ois_pkg::OP_ADD, '0);
        send_request(ois_pkg::OP_QUERY, '1);
        send_request(ois_pkg::OP_REMOVE, '0);
        send_request(ois_pkg::OP_QUERY, '0);
        for (int i = 0; i < LIST_DEPTH - 2; i++)
            send_request(ois_pkg::OP_ADD, 22'h2AAAAA ^ ois_pkg::ID_W'(i));
        send_request(ois_pkg::OP_ADD, 22'h155555);
        send_request(OP_UNUSED, 22'h155555);
        send_request(ois_pkg::OP_REMOVE, 22'h2AAAAA ^ ois_pkg::ID_W'(LIST_DEPTH - 3));
        send_request(ois_pkg::OP_REMOVE, '1);
        send_request(ois_pkg::OP_REMOVE, 22'h155555);

        // Phase 1: no idling on either side.
        refresh_pool();
        run_random(480);

        // Phase 2: sender idles about half the time; midway, hold the
        // response side off while requests keep coming.
        send_idle_pct = 47;
        refresh_pool();
        run_random(240);
        hold_orders <= hold_orders + 1;
        run_random(240);

        // Phase 3: receiver stalls about half the time; midway, pause the
        // sender until everything outstanding has come back.
        send_idle_pct = 0;
        stall_pct     = 47;
        refresh_pool();
        run_random(240);
        wait_for_results();
        run_random(240);

        // Phase 4: light idling on both sides.
        send_idle_pct = 17;
        stall_pct     = 17;
        refresh_pool();
        run_random(470);

        wait_for_results();
        if (list_chk.pending() != 0)
        begin
            $error("%0d responses never arrived", list_chk.pending());
            list_chk.mismatches++;
        end

        $display("Checked %0d responses to %0d requests; list reached %0d of %0d entries.",
                 list_chk.responses, list_chk.requests, list_chk.peak_fill, LIST_DEPTH);
        $display("Saw %0d refused adds, %0d removals and %0d query hits.",
                 list_chk.refused_adds, list_chk.removals, list_chk.query_hits);
        if (list_chk.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> ordered_id_set_add_remove_query_top.f
design/ois_pkg.sv
design/ois_ram.sv
design/ois_engine.sv
design/ordered_id_set_add_remove_query_top.sv
test/tb_top.sv
